### rtl/core/srcmp_pkg.sv
// Shared types, register indexes and helper functions of the compensation core.
`default_nettype none
package srcmp_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_TEMP    = 3'd0;
	localparam logic [2:0] REG_PRESS_L = 3'd1;
	localparam logic [2:0] REG_PRESS_H = 3'd2;
	localparam logic [2:0] REG_PRESS_9 = 3'd3;
	localparam logic [2:0] REG_HUMID_L = 3'd4;
	localparam logic [2:0] REG_HUMID_H = 3'd5;

	// humidity clamp: raw limit and the same value after the final shift
	localparam logic [31:0] HUM_MAX_RAW = 32'd419430400;
	localparam logic [16:0] HUM_MAX_OUT = 17'd102400;

	// decoded calibration coefficients
	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [15:0] h4;
		logic [15:0] h5;
		logic [7:0]  h6;
	} coeff_t;

	// work handed from the front to the back
	typedef struct packed {
		logic [31:0] temp;
		logic [63:0] num;
		logic [63:0] div;
		logic [16:0] hum;
	} mid_item_t;

	typedef enum logic [4:0] {
		FE_IDLE, FE_T1, FE_T2, FE_T3, FE_PAA, FE_PB6, FE_PA5, FE_PA3, FE_PA2, FE_PA1,
		FE_PN, FE_H5, FE_H6, FE_H3, FE_HTU, FE_H2, FE_HXY, FE_HQQ, FE_H1, FE_PUSH
	} fe_state_t;

	typedef enum logic [2:0] {
		BE_IDLE, BE_DIV, BE_M9S, BE_MSS, BE_M8, BE_OUT
	} be_state_t;

	typedef enum logic [1:0] {
		DV_IDLE, DV_RUN, DV_DONE
	} dv_state_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] sx16_64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx8_64(input logic [7:0] v);
		return {{56{v[7]}}, v};
	endfunction

endpackage
`default_nettype wire

### rtl/core/sensor_reading_compensation_core.sv
// Top level of the sensor reading compensation core: registers, front, queue and back.
//
// channel   direction  handshake            payload
// sample    in         push / full          adc_temp, adc_press, adc_humid
// result    out        pop / empty          temperature_centi, pressure_q24_8,
//                                           pressure_invalid, humidity_q22_10
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Sustained throughput is set by the front sequencer: eighteen passes through its shared
// multiplier. The back (divider plus three multiplier passes) runs on the previous sample
// in parallel, so the front can take a new sample before the back is through with the last.
// Reset clears all control state and the coefficients.
// A waiting result stalls only the back; the front keeps going until the queue fills.
`default_nettype none
module sensor_reading_compensation_core
	import srcmp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [19:0] adc_temp,
	input  wire logic [19:0] adc_press,
	input  wire logic [15:0] adc_humid,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      temperature_centi,
	output logic [31:0]      pressure_q24_8,
	output logic             pressure_invalid,
	output logic [16:0]      humidity_q22_10,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [47:0] temp_q;
	logic [63:0] press_l_q, press_h_q;
	logic [15:0] press_9_q;
	logic [31:0] humid_l_q;
	logic [39:0] humid_h_q;
	coeff_t      cf;

	logic        q_push, q_full, q_pop, q_empty;
	mid_item_t   q_in, q_out;

	assign cfg_ready = 1'b1;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q    <= '0;
			press_l_q <= '0;
			press_h_q <= '0;
			press_9_q <= '0;
			humid_l_q <= '0;
			humid_h_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEMP:    temp_q    <= cfg_data[47:0];
				REG_PRESS_L: press_l_q <= cfg_data;
				REG_PRESS_H: press_h_q <= cfg_data;
				REG_PRESS_9: press_9_q <= cfg_data[15:0];
				REG_HUMID_L: humid_l_q <= cfg_data[31:0];
				REG_HUMID_H: humid_h_q <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	// field decode
	always_comb begin
		cf.t1 = temp_q[15:0];
		cf.t2 = temp_q[31:16];
		cf.t3 = temp_q[47:32];
		cf.p1 = press_l_q[15:0];
		cf.p2 = press_l_q[31:16];
		cf.p3 = press_l_q[47:32];
		cf.p4 = press_l_q[63:48];
		cf.p5 = press_h_q[15:0];
		cf.p6 = press_h_q[31:16];
		cf.p7 = press_h_q[47:32];
		cf.p8 = press_h_q[63:48];
		cf.p9 = press_9_q;
		cf.h1 = humid_l_q[7:0];
		cf.h2 = humid_l_q[23:8];
		cf.h3 = humid_l_q[31:24];
		cf.h4 = humid_h_q[15:0];
		cf.h5 = humid_h_q[31:16];
		cf.h6 = humid_h_q[39:32];
	end

	srcmp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cf        (cf),
		.push      (push),
		.full      (full),
		.adc_temp  (adc_temp),
		.adc_press (adc_press),
		.adc_humid (adc_humid),
		.q_push    (q_push),
		.q_full    (q_full),
		.q_item    (q_in)
	);

	srcmp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_out),
		.empty  (q_empty)
	);

	srcmp_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cf                (cf),
		.q_item            (q_out),
		.q_empty           (q_empty),
		.q_pop             (q_pop),
		.empty             (empty),
		.pop               (pop),
		.temperature_centi (temperature_centi),
		.pressure_q24_8    (pressure_q24_8),
		.pressure_invalid  (pressure_invalid),
		.humidity_q22_10   (humidity_q22_10)
	);

	// queue transactions stay within its bounds
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("front pushed into a full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("back popped an empty queue");

	// a zero divisor reports zero pressure
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pressure_invalid) |-> (pressure_q24_8 == 32'd0))
		else $error("invalid pressure is not zero");

	// humidity stays within 0..100 percent
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (humidity_q22_10 <= HUM_MAX_OUT)) else $error("humidity out of range");

endmodule
`default_nettype wire

### rtl/core/srcmp_mul64.sv
// Shared multiplier: low 64 bits of a 64x64 product from three 32x32 partial products.
`default_nettype none
module srcmp_mul64
	import srcmp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      p
);

	logic [63:0] a_q, b_q, acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q, done_q;
	logic [31:0] x, y;
	logic [63:0] prod;

	// one partial product per cycle
	assign x    = (cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign y    = (cnt_q == 2'd1) ? b_q[63:32] : b_q[31:0];
	assign prod = x * y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (cnt_q == 2'd0) acc_q <= prod;
			else acc_q <= acc_q + {prod[31:0], 32'd0};
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule
`default_nettype wire

### rtl/core/srcmp_div64.sv
// Signed 64-bit divider, restoring radix 2, one quotient bit per cycle.
`default_nettype none
module srcmp_div64
	import srcmp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] n,
	input  wire logic [63:0] d,
	output logic             done,
	output logic [63:0]      q
);

	dv_state_t   state_q, state_d;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q, quo_q, md_q;
	logic        neg_q;
	logic [64:0] rem_sh, diff;

	assign rem_sh = {rem_q, quo_q[63]};
	assign diff   = rem_sh - {1'b0, md_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= DV_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			DV_IDLE: if (start) state_d = DV_RUN;
			DV_RUN:  if (cnt_q == 6'd63) state_d = DV_DONE;
			DV_DONE: begin
				done    = 1'b1;
				state_d = DV_IDLE;
			end
			default: state_d = DV_IDLE;
		endcase
	end

	// magnitudes in, shift-subtract loop
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			quo_q <= n[63] ? (64'd0 - n) : n;
			md_q  <= d[63] ? (64'd0 - d) : d;
			neg_q <= n[63] ^ d[63];
			rem_q <= 64'd0;
			cnt_q <= 6'd0;
		end else if (state_q == DV_RUN) begin
			cnt_q <= cnt_q + 6'd1;
			quo_q <= {quo_q[62:0], ~diff[64]};
			rem_q <= diff[64] ? rem_sh[63:0] : diff[63:0];
		end
	end

	assign q = neg_q ? (64'd0 - quo_q) : quo_q;

endmodule
`default_nettype wire

### rtl/core/srcmp_queue.sv
// Two-entry queue between the front and the back.
`default_nettype none
module srcmp_queue
	import srcmp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire mid_item_t din,
	output logic           full,
	input  wire logic      pop,
	output mid_item_t      dout,
	output logic           empty
);

	mid_item_t  mem [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= din;
	end

endmodule
`default_nettype wire

### rtl/core/srcmp_front.sv
// Front: takes raw samples, computes temperature, humidity and the pressure division operands.
`default_nettype none
module srcmp_front
	import srcmp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire coeff_t      cf,
	input  wire logic        push,
	output logic             full,
	input  wire logic [19:0] adc_temp,
	input  wire logic [19:0] adc_press,
	input  wire logic [15:0] adc_humid,
	output logic             q_push,
	input  wire logic        q_full,
	output mid_item_t        q_item
);

	// holding register for the next sample
	logic        hold_v_q;
	logic [19:0] hold_t_q, hold_p_q;
	logic [15:0] hold_h_q;

	fe_state_t   state_q, state_d;
	logic        issued_q, take;
	logic        mul_start, mul_done;
	logic [63:0] mul_a, mul_b, mul_p;
	logic [31:0] r32;

	logic [19:0] adc_t_q, adc_p_q;
	logic [15:0] adc_h_q;
	logic [31:0] v1_q, dd_q, tfine_q;
	logic [63:0] aa_q, pb_q, px_q, pdiv_q, pnum_q;
	logic [31:0] hx_q, ht_q, hu_q, hy_q, hv_q;

	logic [63:0] a0, pnum_base;
	logic [31:0] dt1, dt2, vh, hq, tf5;

	assign full = hold_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_v_q <= 1'b0;
		else if (push && !hold_v_q) hold_v_q <= 1'b1;
		else if (take) hold_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push && !hold_v_q) begin
			hold_t_q <= adc_temp;
			hold_p_q <= adc_press;
			hold_h_q <= adc_humid;
		end
	end

	srcmp_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign r32 = mul_p[31:0];

	// working terms
	assign dt1       = {15'd0, adc_t_q[19:3]} - {15'd0, cf.t1, 1'b0};
	assign dt2       = {16'd0, adc_t_q[19:4]} - {16'd0, cf.t1};
	assign a0        = {{32{tfine_q[31]}}, tfine_q} - 64'd128000;
	assign pnum_base = ((64'd1048576 - {44'd0, adc_p_q}) << 31) - pb_q;
	assign vh        = tfine_q - 32'd76800;
	assign hq        = asr32(hv_q, 15);
	assign tf5       = tfine_q + {tfine_q[29:0], 2'b00} + 32'd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FE_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_done) issued_q <= 1'b0;
			else if (mul_start) issued_q <= 1'b1;
		end
	end

	// step sequencer: operand select per step
	always_comb begin
		state_d = state_q;
		mul_a   = 64'd0;
		mul_b   = 64'd0;
		take    = 1'b0;
		q_push  = 1'b0;
		unique case (state_q)
			FE_IDLE: if (hold_v_q) begin
				take    = 1'b1;
				state_d = FE_T1;
			end
			FE_T1: begin
				mul_a = {32'd0, dt1};
				mul_b = sx16_64(cf.t2);
				if (mul_done) state_d = FE_T2;
			end
			FE_T2: begin
				mul_a = {32'd0, dt2};
				mul_b = {32'd0, dt2};
				if (mul_done) state_d = FE_T3;
			end
			FE_T3: begin
				mul_a = {32'd0, dd_q};
				mul_b = sx16_64(cf.t3);
				if (mul_done) state_d = FE_PAA;
			end
			FE_PAA: begin
				mul_a = a0;
				mul_b = a0;
				if (mul_done) state_d = FE_PB6;
			end
			FE_PB6: begin
				mul_a = aa_q;
				mul_b = sx16_64(cf.p6);
				if (mul_done) state_d = FE_PA5;
			end
			FE_PA5: begin
				mul_a = a0;
				mul_b = sx16_64(cf.p5);
				if (mul_done) state_d = FE_PA3;
			end
			FE_PA3: begin
				mul_a = aa_q;
				mul_b = sx16_64(cf.p3);
				if (mul_done) state_d = FE_PA2;
			end
			FE_PA2: begin
				mul_a = a0;
				mul_b = sx16_64(cf.p2);
				if (mul_done) state_d = FE_PA1;
			end
			FE_PA1: begin
				mul_a = 64'h0000_8000_0000_0000 + px_q;
				mul_b = {48'd0, cf.p1};
				if (mul_done) state_d = FE_PN;
			end
			FE_PN: begin
				mul_a = pnum_base;
				mul_b = 64'd3125;
				if (mul_done) state_d = FE_H5;
			end
			FE_H5: begin
				mul_a = {32'd0, vh};
				mul_b = sx16_64(cf.h5);
				if (mul_done) state_d = FE_H6;
			end
			FE_H6: begin
				mul_a = {32'd0, vh};
				mul_b = sx8_64(cf.h6);
				if (mul_done) state_d = FE_H3;
			end
			FE_H3: begin
				mul_a = {32'd0, vh};
				mul_b = {56'd0, cf.h3};
				if (mul_done) state_d = FE_HTU;
			end
			FE_HTU: begin
				mul_a = {32'd0, ht_q};
				mul_b = {32'd0, hu_q};
				if (mul_done) state_d = FE_H2;
			end
			FE_H2: begin
				mul_a = {32'd0, hy_q};
				mul_b = sx16_64(cf.h2);
				if (mul_done) state_d = FE_HXY;
			end
			FE_HXY: begin
				mul_a = {32'd0, hx_q};
				mul_b = {32'd0, hy_q};
				if (mul_done) state_d = FE_HQQ;
			end
			FE_HQQ: begin
				mul_a = {32'd0, hq};
				mul_b = {32'd0, hq};
				if (mul_done) state_d = FE_H1;
			end
			FE_H1: begin
				mul_a = {32'd0, ht_q};
				mul_b = {56'd0, cf.h1};
				if (mul_done) state_d = FE_PUSH;
			end
			FE_PUSH: if (!q_full) begin
				q_push  = 1'b1;
				state_d = FE_IDLE;
			end
			default: state_d = FE_IDLE;
		endcase
		mul_start = (state_q != FE_IDLE) && (state_q != FE_PUSH) && !issued_q;
	end

	// results of each step
	always_ff @(posedge clk) begin
		if (take) begin
			adc_t_q <= hold_t_q;
			adc_p_q <= hold_p_q;
			adc_h_q <= hold_h_q;
		end
		if (mul_done) begin
			unique case (state_q)
				FE_T1:  v1_q    <= asr32(r32, 11);
				FE_T2:  dd_q    <= asr32(r32, 12);
				FE_T3:  tfine_q <= v1_q + asr32(r32, 14);
				FE_PAA: aa_q    <= mul_p;
				FE_PB6: pb_q    <= mul_p;
				FE_PA5: pb_q    <= pb_q + (mul_p << 17) + (sx16_64(cf.p4) << 35);
				FE_PA3: px_q    <= asr64(mul_p, 8);
				FE_PA2: px_q    <= px_q + (mul_p << 12);
				FE_PA1: pdiv_q  <= asr64(mul_p, 33);
				FE_PN:  pnum_q  <= mul_p;
				FE_H5:  hx_q    <= asr32({2'b00, adc_h_q, 14'd0} - {cf.h4[11:0], 20'd0}
					- r32 + 32'd16384, 15);
				FE_H6:  ht_q    <= asr32(r32, 10);
				FE_H3:  hu_q    <= asr32(r32, 11) + 32'd32768;
				FE_HTU: hy_q    <= asr32(r32, 10) + 32'd2097152;
				FE_H2:  hy_q    <= asr32(r32 + 32'd8192, 14);
				FE_HXY: hv_q    <= r32;
				FE_HQQ: ht_q    <= asr32(r32, 7);
				FE_H1:  hv_q    <= hv_q - asr32(r32, 4);
				default: ;
			endcase
		end
	end

	// finished terms, humidity clamped to 0..100 percent
	always_comb begin
		q_item.temp = asr32(tf5, 8);
		q_item.num  = pnum_q;
		q_item.div  = pdiv_q;
		if (hv_q[31]) q_item.hum = 17'd0;
		else if (hv_q > HUM_MAX_RAW) q_item.hum = HUM_MAX_OUT;
		else q_item.hum = hv_q[28:12];
	end

endmodule
`default_nettype wire

### rtl/core/srcmp_back.sv
// Back: pressure division and final pressure terms, result register.
`default_nettype none
module srcmp_back
	import srcmp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire coeff_t    cf,
	input  wire mid_item_t q_item,
	input  wire logic      q_empty,
	output logic           q_pop,
	output logic           empty,
	input  wire logic      pop,
	output logic [31:0]    temperature_centi,
	output logic [31:0]    pressure_q24_8,
	output logic           pressure_invalid,
	output logic [16:0]    humidity_q22_10
);

	be_state_t   state_q, state_d;
	logic        issued_q;
	logic        mul_start, mul_done, div_start, div_done;
	logic [63:0] mul_a, mul_b, mul_p, div_q;
	logic        res_v_q, load;

	logic [31:0] temp_q;
	logic [16:0] hum_q;
	logic [63:0] num_q, den_q, bp_q, bm_q, ba_q, bsum_q;
	logic        inv_q;
	logic [63:0] bs;
	logic [31:0] press;

	srcmp_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	srcmp_div64 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (num_q),
		.d      (den_q),
		.done   (div_done),
		.q      (div_q)
	);

	assign bs    = asr64(bp_q, 13);
	assign press = inv_q ? 32'd0 : bsum_q[39:8] + {{12{cf.p7[15]}}, cf.p7, 4'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BE_IDLE;
			issued_q <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_done || div_done) issued_q <= 1'b0;
			else if (mul_start || div_start) issued_q <= 1'b1;
			if (load) res_v_q <= 1'b1;
			else if (pop) res_v_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = 64'd0;
		mul_b   = 64'd0;
		q_pop   = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			BE_IDLE: if (!q_empty) begin
				q_pop   = 1'b1;
				state_d = (q_item.div == 64'd0) ? BE_OUT : BE_DIV;
			end
			BE_DIV: if (div_done) state_d = BE_M9S;
			BE_M9S: begin
				mul_a = sx16_64(cf.p9);
				mul_b = bs;
				if (mul_done) state_d = BE_MSS;
			end
			BE_MSS: begin
				mul_a = bm_q;
				mul_b = bs;
				if (mul_done) state_d = BE_M8;
			end
			BE_M8: begin
				mul_a = sx16_64(cf.p8);
				mul_b = bp_q;
				if (mul_done) state_d = BE_OUT;
			end
			BE_OUT: if (!res_v_q || pop) begin
				load    = 1'b1;
				state_d = BE_IDLE;
			end
			default: state_d = BE_IDLE;
		endcase
		div_start = (state_q == BE_DIV) && !issued_q;
		mul_start = (state_q == BE_M9S || state_q == BE_MSS || state_q == BE_M8) && !issued_q;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			temp_q <= q_item.temp;
			hum_q  <= q_item.hum;
			num_q  <= q_item.num;
			den_q  <= q_item.div;
			inv_q  <= (q_item.div == 64'd0);
		end
		if (div_done) bp_q <= div_q;
		if (mul_done) begin
			unique case (state_q)
				BE_M9S: bm_q   <= mul_p;
				BE_MSS: ba_q   <= asr64(mul_p, 25);
				BE_M8:  bsum_q <= bp_q + ba_q + asr64(mul_p, 19);
				default: ;
			endcase
		end
		if (load) begin
			temperature_centi <= temp_q;
			pressure_q24_8    <= press;
			pressure_invalid  <= inv_q;
			humidity_q22_10   <= hum_q;
		end
	end

	assign empty = !res_v_q;

endmodule
`default_nettype wire
